FILE: hw/rtl/i2csb_pkg.sv
// Types and codes shared by the I2C slave buffer handler.
// Holds the event codes, the bus action codes and the stage record.
package i2csb_pkg;

  typedef enum logic [3:0] {
    REQ_ADDR_WRITE  = 4'd0,
    REQ_BYTE_RX     = 4'd1,
    REQ_ADDR_MASTER = 4'd2,
    REQ_STOP        = 4'd3,
    REQ_RX_NACKED   = 4'd4,
    REQ_ADDR_READ   = 4'd5,
    REQ_TX_ACKED    = 4'd6,
    REQ_LAST_ACKED  = 4'd7,
    REQ_LAST_NACKED = 4'd8,
    REQ_BUS_ERROR   = 4'd9,
    REQ_HOST_WRITE  = 4'd10,
    REQ_HOST_READ   = 4'd11,
    REQ_HOST_CLEAR  = 4'd12
  } req_t;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_ACK   = 2'd1,
    ACT_NACK  = 2'd2,
    ACT_RESET = 2'd3
  } act_t;

  typedef struct packed {
    act_t act;
    logic tx_load;
    logic tx_hit;
    logic host_rd;
    logic rx_hit;
    logic fault;
  } stage_t;

endpackage

FILE: hw/rtl/i2csb_req_if.sv
// Request channel of the I2C slave buffer handler: one bus event or host access per beat.
// No dependencies.
interface i2csb_req_if;
  logic       valid;
  logic       ready;
  logic [3:0] req_type;
  logic [7:0] data_byte;
  logic [3:0] entry_index;

  modport source (output valid, req_type, data_byte, entry_index, input ready);
  modport sink (input valid, req_type, data_byte, entry_index, output ready);
endinterface

FILE: hw/rtl/i2csb_rsp_if.sv
// Response channel of the I2C slave buffer handler: one result per beat.
// No dependencies.
interface i2csb_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] bus_action;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic [7:0] host_data;
  logic       fault;

  modport source (output valid, bus_action, tx_valid, tx_byte, host_data, fault,
                  input ready);
  modport sink (input valid, bus_action, tx_valid, tx_byte, host_data, fault,
                output ready);
endinterface

FILE: hw/rtl/i2csb_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module i2csb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/i2c_slave_buffer_handler.sv
// Top level of the I2C slave buffer handler.
// Depends on i2csb_pkg, i2csb_req_if, i2csb_rsp_if and i2csb_ram.
//
// Usage:
// - req carries one bus event or host access per beat (req_type, data_byte,
//   entry_index); rsp returns exactly one result per request, in order.
// - Indexes, the fault flag and the entry valid bits update on the cycle a
//   request is taken; the receive and transmit buffers sit in two RAMs whose
//   read is issued at that same cycle.
// - The RAM and stage register load at the beat; the output register follows.
// - Throughput: one request per cycle while rsp does not stall, limited by the
//   single RAM read port of each buffer; a new request is taken while a
//   result waits on rsp.
// - Reset clears the indexes, the fault flag and every entry valid bit, so
//   all entries read as zero; no clearing pass is needed.
// - A host clear drops every receive valid bit together when it is taken.
// - When rsp stalls, the RAM stage and the output register fill, then req
//   ready drops; nothing is lost or repeated.
module i2c_slave_buffer_handler #(
  parameter int RX_DEPTH = 16,
  parameter int TX_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  i2csb_req_if.sink   req,
  i2csb_rsp_if.source rsp
);

  localparam int RxAw = $clog2(RX_DEPTH);
  localparam int TxAw = $clog2(TX_DEPTH);
  localparam int RxPw = $clog2(RX_DEPTH + 1);
  localparam int TxPw = $clog2(TX_DEPTH + 1);

  logic [RxPw-1:0] rx_pos, rx_pos_next;
  logic [TxPw-1:0] tx_pos, tx_pos_next;
  logic            fault_flag, fault_flag_next;
  logic [RX_DEPTH-1:0] rx_vld, rx_vld_next;
  logic [TX_DEPTH-1:0] tx_vld, tx_vld_next;

  logic            accept;
  logic            s1_valid;
  logic            s1_adv;
  i2csb_pkg::stage_t s1, s1_next;

  logic            rx_we, tx_we;
  logic [RxAw-1:0] rx_waddr, rx_raddr;
  logic [TxAw-1:0] tx_waddr, tx_raddr;
  logic [7:0]      rx_wdata, tx_wdata;
  logic [7:0]      rx_rdata, tx_rdata;
  logic            idx_in_rx, idx_in_tx;

  assign s1_adv    = s1_valid && (!rsp.valid || rsp.ready);
  assign req.ready = !s1_valid || !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign idx_in_rx = 32'(req.entry_index) < RX_DEPTH;
  assign idx_in_tx = 32'(req.entry_index) < TX_DEPTH;

  always_comb begin
    rx_pos_next     = rx_pos;
    tx_pos_next     = tx_pos;
    fault_flag_next = fault_flag;
    rx_vld_next     = rx_vld;
    tx_vld_next     = tx_vld;
    rx_we           = 1'b0;
    tx_we           = 1'b0;
    rx_waddr        = RxAw'(rx_pos);
    rx_wdata        = req.data_byte;
    tx_waddr        = TxAw'(req.entry_index);
    tx_wdata        = req.data_byte;
    rx_raddr        = RxAw'(req.entry_index);
    tx_raddr        = '0;
    s1_next         = '0;
    s1_next.act     = i2csb_pkg::ACT_NONE;
    case (i2csb_pkg::req_t'(req.req_type))
      i2csb_pkg::REQ_ADDR_WRITE: begin
        rx_pos_next = '0;
        s1_next.act = i2csb_pkg::ACT_ACK;
      end
      i2csb_pkg::REQ_BYTE_RX: begin
        if (rx_pos != RxPw'(RX_DEPTH)) begin
          rx_we               = 1'b1;
          rx_vld_next[rx_waddr] = 1'b1;
          rx_pos_next         = rx_pos + RxPw'(1);
        end
        s1_next.act = (rx_pos_next == RxPw'(RX_DEPTH)) ? i2csb_pkg::ACT_NACK
                                                       : i2csb_pkg::ACT_ACK;
      end
      i2csb_pkg::REQ_ADDR_MASTER: begin
        fault_flag_next = 1'b1;
        s1_next.act     = i2csb_pkg::ACT_ACK;
      end
      i2csb_pkg::REQ_STOP, i2csb_pkg::REQ_RX_NACKED,
      i2csb_pkg::REQ_LAST_ACKED, i2csb_pkg::REQ_LAST_NACKED: begin
        s1_next.act = i2csb_pkg::ACT_ACK;
      end
      i2csb_pkg::REQ_ADDR_READ: begin
        tx_raddr        = '0;
        tx_pos_next     = TxPw'(1);
        s1_next.tx_load = 1'b1;
        s1_next.tx_hit  = tx_vld[0];
        s1_next.act     = i2csb_pkg::ACT_ACK;
      end
      i2csb_pkg::REQ_TX_ACKED: begin
        if (tx_pos != TxPw'(TX_DEPTH)) begin
          tx_raddr        = TxAw'(tx_pos);
          tx_pos_next     = tx_pos + TxPw'(1);
          s1_next.tx_load = 1'b1;
          s1_next.tx_hit  = tx_vld[tx_raddr];
        end
        s1_next.act = (tx_pos_next == TxPw'(TX_DEPTH)) ? i2csb_pkg::ACT_NACK
                                                       : i2csb_pkg::ACT_ACK;
      end
      i2csb_pkg::REQ_BUS_ERROR: begin
        s1_next.act = i2csb_pkg::ACT_RESET;
      end
      i2csb_pkg::REQ_HOST_WRITE: begin
        if (idx_in_tx) begin
          tx_we                 = 1'b1;
          tx_vld_next[tx_waddr] = 1'b1;
        end
      end
      i2csb_pkg::REQ_HOST_READ: begin
        s1_next.host_rd = 1'b1;
        s1_next.rx_hit  = idx_in_rx && rx_vld[rx_raddr];
      end
      i2csb_pkg::REQ_HOST_CLEAR: begin
        rx_vld_next = '0;
      end
      default: begin
      end
    endcase
    s1_next.fault = fault_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_pos     <= '0;
      tx_pos     <= '0;
      fault_flag <= 1'b0;
      rx_vld     <= '0;
      tx_vld     <= '0;
    end else if (accept) begin
      rx_pos     <= rx_pos_next;
      tx_pos     <= tx_pos_next;
      fault_flag <= fault_flag_next;
      rx_vld     <= rx_vld_next;
      tx_vld     <= tx_vld_next;
    end
  end

  i2csb_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (accept && rx_we),
    .waddr (rx_waddr),
    .wdata (rx_wdata),
    .re    (accept),
    .raddr (rx_raddr),
    .rdata (rx_rdata)
  );

  i2csb_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (accept && tx_we),
    .waddr (tx_waddr),
    .wdata (tx_wdata),
    .re    (accept),
    .raddr (tx_raddr),
    .rdata (tx_rdata)
  );

  // RAM stage: hold while the output register is blocked
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= s1_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (s1_adv) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      rsp.bus_action <= s1.act;
      rsp.tx_valid   <= s1.tx_load;
      rsp.tx_byte    <= (s1.tx_load && s1.tx_hit) ? tx_rdata : 8'd0;
      rsp.host_data  <= (s1.host_rd && s1.rx_hit) ? rx_rdata : 8'd0;
      rsp.fault      <= s1.fault;
    end
  end

endmodule

FILE: test/i2csb_reply_checker.sv
`timescale 1ns / 100ps
// Reply checker for the I2C slave buffer handler: predicts each reply from the request beats
// and compares it field by field with the rsp beats. Depends on i2csb_pkg, i2csb_req_if and
// i2csb_rsp_if.
module i2csb_reply_checker #(
  parameter int RX_DEPTH = 16,
  parameter int TX_DEPTH = 16
) (
  input  logic  clk,
  input  logic  rst,
  i2csb_req_if  req,
  i2csb_rsp_if  rsp,
  output int    errors,
  output int    pending,
  output int    checked
);
  import i2csb_pkg::*;

  localparam int RxPw = $clog2(RX_DEPTH + 1);
  localparam int TxPw = $clog2(TX_DEPTH + 1);

  typedef struct packed {
    act_t       act;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [7:0] host_data;
    logic       fault;
  } reply_t;

  logic [7:0]      rx_mem [RX_DEPTH];
  logic [7:0]      tx_mem [TX_DEPTH];
  logic [RxPw-1:0] rx_pos_q;
  logic [TxPw-1:0] tx_pos_q;
  logic            fault_q;
  reply_t          due_replies [$];

  task automatic apply_event(input req_t kind, input logic [7:0] value,
                             input logic [3:0] idx, output reply_t res);
    res = '0;
    case (kind)
      REQ_ADDR_WRITE: begin
        rx_pos_q = '0;
        res.act  = ACT_ACK;
      end
      REQ_BYTE_RX: begin
        if (rx_pos_q < RX_DEPTH) begin
          rx_mem[rx_pos_q] = value;
          rx_pos_q = rx_pos_q + RxPw'(1);
        end
        res.act = (rx_pos_q >= RX_DEPTH) ? ACT_NACK : ACT_ACK;
      end
      REQ_ADDR_MASTER: begin
        fault_q = 1'b1;
        res.act = ACT_ACK;
      end
      REQ_STOP, REQ_RX_NACKED, REQ_LAST_ACKED, REQ_LAST_NACKED: begin
        res.act = ACT_ACK;
      end
      REQ_ADDR_READ: begin
        tx_pos_q     = TxPw'(1);
        res.tx_valid = 1'b1;
        res.tx_byte  = tx_mem[0];
        res.act      = ACT_ACK;
      end
      REQ_TX_ACKED: begin
        if (tx_pos_q < TX_DEPTH) begin
          res.tx_valid = 1'b1;
          res.tx_byte  = tx_mem[tx_pos_q];
          tx_pos_q     = tx_pos_q + TxPw'(1);
        end
        res.act = (tx_pos_q >= TX_DEPTH) ? ACT_NACK : ACT_ACK;
      end
      REQ_BUS_ERROR: begin
        res.act = ACT_RESET;
      end
      REQ_HOST_WRITE: begin
        if (idx < TX_DEPTH) tx_mem[idx] = value;
      end
      REQ_HOST_READ: begin
        if (idx < RX_DEPTH) res.host_data = rx_mem[idx];
      end
      REQ_HOST_CLEAR: begin
        foreach (rx_mem[i]) rx_mem[i] = '0;
      end
      default: begin
      end
    endcase
    res.fault = fault_q;
  endtask

  task automatic flag_field(input string name, input int want, input int got);
    $display("%0t: reply mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
    errors++;
  endtask

  always @(posedge clk) begin
    reply_t want;
    reply_t got;
    if (rst) begin
      foreach (rx_mem[i]) rx_mem[i] = '0;
      foreach (tx_mem[i]) tx_mem[i] = '0;
      rx_pos_q = '0;
      tx_pos_q = '0;
      fault_q  = 1'b0;
      due_replies.delete();
      errors   = 0;
      checked  = 0;
    end else begin
      if (req.valid && req.ready) begin
        apply_event(req_t'(req.req_type), req.data_byte, req.entry_index, want);
        due_replies.push_back(want);
      end
      if (rsp.valid && rsp.ready) begin
        got = {rsp.bus_action, rsp.tx_valid, rsp.tx_byte, rsp.host_data, rsp.fault};
        if (due_replies.size() == 0) begin
          $display("%0t: reply with none expected: bus_action %0d tx_valid %0d tx_byte %0d",
                   $time, got.act, got.tx_valid, got.tx_byte);
          errors++;
        end else begin
          want = due_replies.pop_front();
          checked++;
          if (got.act != want.act) flag_field("bus_action", want.act, got.act);
          if (got.tx_valid != want.tx_valid) flag_field("tx_valid", want.tx_valid, got.tx_valid);
          if (got.tx_byte != want.tx_byte) flag_field("tx_byte", want.tx_byte, got.tx_byte);
          if (got.host_data != want.host_data) begin
            flag_field("host_data", want.host_data, got.host_data);
          end
          if (got.fault != want.fault) flag_field("fault", want.fault, got.fault);
        end
      end
    end
    pending = due_replies.size();
  end

endmodule

FILE: test/i2c_slave_buffer_handler_tb.sv
`timescale 1ns / 100ps
// Testbench top for the I2C slave buffer handler: drives bus events and host accesses with
// random gaps and stalls; the verdict comes from i2csb_reply_checker. Depends on i2csb_pkg,
// i2csb_req_if, i2csb_rsp_if, i2c_slave_buffer_handler and i2csb_reply_checker.
module i2c_slave_buffer_handler_tb;
  import i2csb_pkg::*;

  localparam int RX_DEPTH   = 16;
  localparam int TX_DEPTH   = 16;
  localparam int ITEM_COUNT = 1150;
  localparam int MAX_GAP    = 17;
  localparam int LIMIT      = 400000;

  logic clk;
  logic rst;
  logic calm;
  int   errors;
  int   pending;
  int   checked;
  int   sent;
  int   directed;
  int   cycles;

  i2csb_req_if req_ch ();
  i2csb_rsp_if rsp_ch ();

  i2c_slave_buffer_handler #(
    .RX_DEPTH(RX_DEPTH),
    .TX_DEPTH(TX_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  i2csb_reply_checker #(
    .RX_DEPTH(RX_DEPTH),
    .TX_DEPTH(TX_DEPTH)
  ) u_checker (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .errors(errors),
    .pending(pending),
    .checked(checked)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  initial cycles = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("%0t: timeout with %0d replies outstanding", $time, pending);
      $display("[i2c_slave_buffer_handler] ERROR");
      $finish;
    end
  end

  task automatic send_beat(input req_t kind, input logic [7:0] value, input logic [3:0] idx);
    int gap;
    gap = calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= kind;
    req_ch.data_byte   <= value;
    req_ch.entry_index <= idx;
    @(posedge clk);
    while (!(req_ch.valid && req_ch.ready)) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_rand(input req_t kind);
    send_beat(kind, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
  endtask

  task automatic drain;
    req_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  function automatic int burst_len();
    return ($urandom_range(0, 2) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 8);
  endfunction

  task automatic write_burst;
    int n;
    n = burst_len();
    send_rand(REQ_ADDR_WRITE);
    repeat (n) send_rand(REQ_BYTE_RX);
    send_rand(($urandom_range(0, 1) == 0) ? REQ_STOP : REQ_RX_NACKED);
  endtask

  task automatic read_burst;
    int n;
    n = burst_len();
    send_rand(REQ_ADDR_READ);
    repeat (n) send_rand(REQ_TX_ACKED);
    send_rand(($urandom_range(0, 1) == 0) ? REQ_LAST_ACKED : REQ_LAST_NACKED);
    send_rand(REQ_STOP);
  endtask

  task automatic host_burst;
    int n;
    n = $urandom_range(1, 5);
    repeat (n) send_rand(($urandom_range(0, 1) == 0) ? REQ_HOST_WRITE : REQ_HOST_READ);
    if ($urandom_range(0, 5) == 0) send_rand(REQ_HOST_CLEAR);
  endtask

  task automatic noise_burst;
    int n;
    n = $urandom_range(1, 3);
    repeat (n) send_rand(req_t'($urandom_range(REQ_ADDR_WRITE, REQ_HOST_CLEAR)));
  endtask

  initial begin
    int stall;
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(rsp_ch.valid && rsp_ch.ready)) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    int next_drain;
    rst                = 1'b1;
    calm               = 1'b0;
    sent               = 0;
    req_ch.valid       = 1'b0;
    req_ch.req_type    = REQ_ADDR_WRITE;
    req_ch.data_byte   = '0;
    req_ch.entry_index = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_beat(REQ_HOST_WRITE, 8'hFF, 4'd0);
    send_beat(REQ_HOST_WRITE, 8'h00, 4'd15);
    send_beat(REQ_HOST_WRITE, 8'hA5, 4'd1);
    send_beat(REQ_ADDR_READ, 8'h00, 4'd0);
    send_beat(REQ_TX_ACKED, 8'hFF, 4'd15);
    send_beat(REQ_TX_ACKED, 8'h00, 4'd0);
    send_beat(REQ_LAST_NACKED, 8'h00, 4'd0);
    send_beat(REQ_STOP, 8'h00, 4'd0);
    send_beat(REQ_ADDR_WRITE, 8'hFF, 4'd15);
    send_beat(REQ_BYTE_RX, 8'h00, 4'd0);
    send_beat(REQ_BYTE_RX, 8'hFF, 4'd0);
    send_beat(REQ_BYTE_RX, 8'h5A, 4'd0);
    send_beat(REQ_RX_NACKED, 8'h00, 4'd0);
    send_beat(REQ_STOP, 8'h00, 4'd0);
    send_beat(REQ_HOST_READ, 8'h00, 4'd0);
    send_beat(REQ_HOST_READ, 8'h00, 4'd1);
    send_beat(REQ_HOST_READ, 8'h00, 4'd15);
    send_beat(REQ_HOST_CLEAR, 8'h00, 4'd0);
    send_beat(REQ_HOST_READ, 8'h00, 4'd1);
    send_beat(REQ_LAST_ACKED, 8'h00, 4'd0);
    send_beat(REQ_BUS_ERROR, 8'h00, 4'd0);
    send_beat(REQ_ADDR_MASTER, 8'h00, 4'd0);
    send_beat(REQ_STOP, 8'h00, 4'd0);
    directed = sent;
    drain();

    next_drain = sent + 300;
    while (sent < ITEM_COUNT + directed) begin
      calm = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2: write_burst();
        3, 4, 5: read_burst();
        6, 7:    host_burst();
        default: noise_burst();
      endcase
      if (sent >= next_drain) begin
        drain();
        next_drain = sent + 300;
      end
    end

    calm = 1'b0;
    drain();
    repeat (8) @(negedge clk);
    $display("Covered %0d requests (%0d directed): bursts past both buffer ends, host accesses,",
             sent, directed);
    $display("clears, faults and bus errors under random gaps and stalls; %0d replies compared",
             checked);
    if (errors == 0) begin
      $display("[i2c_slave_buffer_handler] OK");
    end else begin
      $display("[i2c_slave_buffer_handler] ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/i2csb_pkg.sv
hw/rtl/i2csb_req_if.sv
hw/rtl/i2csb_rsp_if.sv
hw/rtl/i2csb_ram.sv
hw/rtl/i2c_slave_buffer_handler.sv
test/i2csb_reply_checker.sv
test/i2c_slave_buffer_handler_tb.sv
